[design/lrf_pkg.sv]
// ----------------------------------------------------------------------------
// lrf_pkg: shared definitions for the rectangle-fill sequencer
// Constants, codes and the result word type used by the sequencer modules.
// ----------------------------------------------------------------------------
package lrf_pkg;

    // default coordinate width (columns and rows)
    localparam int COORD_BITS_DEF = 10;

    // configuration register indexes
    localparam int               CFG_INDEX_W      = 1;
    localparam [CFG_INDEX_W-1:0] REG_PANEL_WIDTH  = 1'b0;
    localparam [CFG_INDEX_W-1:0] REG_PANEL_HEIGHT = 1'b1;

    // panel size after reset
    localparam int PANEL_WIDTH_RST  = 240;
    localparam int PANEL_HEIGHT_RST = 320;

    // input word kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // display controller commands
    localparam [7:0] CMD_COL_SET   = 8'h2A;
    localparam [7:0] CMD_ROW_SET   = 8'h2B;
    localparam [7:0] CMD_MEM_WRITE = 8'h2C;

    // sequence phases
    localparam int   PHASE_W        = 4;
    localparam [3:0] PH_COL_CMD     = 4'd0;
    localparam [3:0] PH_COL_START_H = 4'd1;
    localparam [3:0] PH_COL_START_L = 4'd2;
    localparam [3:0] PH_COL_END_H   = 4'd3;
    localparam [3:0] PH_COL_END_L   = 4'd4;
    localparam [3:0] PH_ROW_CMD     = 4'd5;
    localparam [3:0] PH_ROW_START_H = 4'd6;
    localparam [3:0] PH_ROW_START_L = 4'd7;
    localparam [3:0] PH_ROW_END_H   = 4'd8;
    localparam [3:0] PH_ROW_END_L   = 4'd9;
    localparam [3:0] PH_MEM_CMD     = 4'd10;
    localparam [3:0] PH_PIXELS      = 4'd11;

    // one bus word toward the display
    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } result_t;

endpackage

[design/lcd_rect_fill_sequencer.sv]
// ----------------------------------------------------------------------------
// lcd_rect_fill_sequencer: rectangle fill to display bus byte sequencer
// Clips a fill request to the panel and emits the column/row window
// commands, the memory-write command and the pixel color bytes, one
// bus byte per word of a running fill.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: kind; tdata: left, top, width,
//          |     |                    |   height, fill_color
//  m_*     | out | m_tvalid/m_tready  | tuser: is_data; tdata: bus_byte;
//          |     |                    |   tlast: last
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data (panel size)
//
// One input word per cycle is taken while the output is not stalled; each
// word leaves at most one bus word through the input register, then the
// sequencer into the output register. The sequencer's next state is combinational.
// Reset clears all fill state and loads a 240 x 320 panel.
// A stall on m_tready holds the output word and, once the input register
// is also full, drops s_tready; no word is lost.
// ----------------------------------------------------------------------------
module lcd_rect_fill_sequencer #(
    parameter int COORD_BITS = lrf_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [lrf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]           cfg_data,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // left, top, width, height, fill_color from bit 0 up, zero padded
    input  logic [((4*COORD_BITS+16+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic                            s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // bus_byte
    output logic [7:0]                      m_tdata,
    // is_data
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int DATA_W = ((4*COORD_BITS + 16 + 7) / 8) * 8;

    logic              item_valid;
    logic [DATA_W-1:0] item_data;
    logic              item_kind;
    logic              out_free;
    logic              advance;
    logic              res_valid;
    lrf_pkg::result_t  res;
    lrf_pkg::result_t  out_word;

    // move the held request into the sequencer when the output can take it
    assign advance = item_valid && out_free;

    lrf_in_reg #(
        .DATA_W (DATA_W)
    ) u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item_data  (item_data),
        .item_kind  (item_kind)
    );

    lrf_seq #(
        .COORD_BITS (COORD_BITS),
        .DATA_W     (DATA_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item_data (item_data),
        .item_kind (item_kind),
        .res_valid (res_valid),
        .res       (res)
    );

    lrf_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .word      (out_word)
    );

    assign m_tdata = out_word.bus_byte;
    assign m_tuser = out_word.is_data;
    assign m_tlast = out_word.last;

endmodule

[design/lrf_in_reg.sv]
// ----------------------------------------------------------------------------
// lrf_in_reg: input register
// Holds one accepted request word until the sequencer takes it.
// ----------------------------------------------------------------------------
module lrf_in_reg #(
    parameter int DATA_W = 56
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              s_tuser,
    input  logic              advance,
    output logic              item_valid,
    output logic [DATA_W-1:0] item_data,
    output logic              item_kind
);

    logic              valid_reg;
    logic [DATA_W-1:0] data_reg;
    logic              kind_reg;

    // free when empty or when the held word leaves this cycle
    assign s_tready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
            kind_reg <= s_tuser;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;
    assign item_kind  = kind_reg;

endmodule

[design/lrf_seq.sv]
// ----------------------------------------------------------------------------
// lrf_seq: sequencer core
// Clips a rectangle, holds the fill state and picks the next bus byte.
// ----------------------------------------------------------------------------
module lrf_seq #(
    parameter int COORD_BITS = lrf_pkg::COORD_BITS_DEF,
    parameter int DATA_W     = 56
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lrf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data,
    input  logic                                advance,
    input  logic [DATA_W-1:0]                   item_data,
    input  logic                                item_kind,
    output logic                                res_valid,
    output lrf_pkg::result_t                    res
);

    localparam int CB    = COORD_BITS;
    localparam int EXT_W = (CB + 1 > 16) ? CB + 1 : 16;

    logic [CB-1:0]  panel_w_reg, panel_w_next;
    logic [CB-1:0]  panel_h_reg, panel_h_next;
    logic           busy_reg, busy_next;
    logic [lrf_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [CB-1:0]  col_start_reg, col_start_next;
    logic [CB:0]    col_end_reg, col_end_next;
    logic [CB-1:0]  row_start_reg, row_start_next;
    logic [CB:0]    row_end_reg, row_end_next;
    logic [15:0]    color_reg, color_next;
    logic [CB-1:0]  cols_left_reg, cols_left_next;
    logic [CB-1:0]  rows_left_reg, rows_left_next;
    logic           low_half_reg, low_half_next;

    logic [CB-1:0]  in_left, in_top, in_width, in_height;
    logic [15:0]    in_color;
    logic           drop;
    logic [CB:0]    sum_x, sum_y;
    logic [CB-1:0]  clip_w, clip_h;
    logic [CB:0]    reload_full;
    logic [CB-1:0]  cols_dec;
    logic [EXT_W-1:0] col_start_ext, col_end_ext, row_start_ext, row_end_ext;

    // unpack the request word, lowest field first
    assign in_left   = item_data[CB-1:0];
    assign in_top    = item_data[2*CB-1:CB];
    assign in_width  = item_data[3*CB-1:2*CB];
    assign in_height = item_data[4*CB-1:3*CB];
    assign in_color  = item_data[4*CB+15:4*CB];

    assign drop   = (in_left >= panel_w_reg) || (in_top >= panel_h_reg);
    assign sum_x  = {1'b0, in_left} + {1'b0, in_width};
    assign sum_y  = {1'b0, in_top} + {1'b0, in_height};
    assign clip_w = (sum_x > {1'b0, panel_w_reg}) ? panel_w_reg - in_left : in_width;
    assign clip_h = (sum_y > {1'b0, panel_h_reg}) ? panel_h_reg - in_top : in_height;

    // column count for the next row
    assign reload_full = col_end_reg - {1'b0, col_start_reg} + (CB+1)'(1);
    assign cols_dec    = cols_left_reg - CB'(1);

    // start coordinates zero-extend, end coordinates sign-extend
    assign col_start_ext = EXT_W'(col_start_reg);
    assign row_start_ext = EXT_W'(row_start_reg);
    assign col_end_ext   = EXT_W'($signed(col_end_reg));
    assign row_end_ext   = EXT_W'($signed(row_end_reg));

    always_comb
    begin
        panel_w_next   = panel_w_reg;
        panel_h_next   = panel_h_reg;
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        col_start_next = col_start_reg;
        col_end_next   = col_end_reg;
        row_start_next = row_start_reg;
        row_end_next   = row_end_reg;
        color_next     = color_reg;
        cols_left_next = cols_left_reg;
        rows_left_next = rows_left_reg;
        low_half_next  = low_half_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                lrf_pkg::REG_PANEL_WIDTH:  panel_w_next = cfg_data;
                lrf_pkg::REG_PANEL_HEIGHT: panel_h_next = cfg_data;
                default: ;
            endcase
        end

        if (advance)
        begin
            if (item_kind == lrf_pkg::KIND_START)
            begin
                // a new start always abandons the fill in progress
                busy_next = 1'b0;
                if (!drop)
                begin
                    col_start_next = in_left;
                    row_start_next = in_top;
                    col_end_next   = {1'b0, in_left} + {1'b0, clip_w} - (CB+1)'(1);
                    row_end_next   = {1'b0, in_top} + {1'b0, clip_h} - (CB+1)'(1);
                    cols_left_next = clip_w;
                    rows_left_next = clip_h;
                    color_next     = in_color;
                    low_half_next  = 1'b0;
                    phase_next     = lrf_pkg::PH_COL_START_H;
                    busy_next      = 1'b1;
                    res_valid      = 1'b1;
                    res.is_data    = 1'b0;
                    res.bus_byte   = lrf_pkg::CMD_COL_SET;
                end
            end
            else if (busy_reg)
            begin
                res_valid   = 1'b1;
                res.is_data = 1'b1;
                phase_next  = phase_reg + lrf_pkg::PHASE_W'(1);
                case (phase_reg)
                    lrf_pkg::PH_COL_CMD:
                    begin
                        res.is_data  = 1'b0;
                        res.bus_byte = lrf_pkg::CMD_COL_SET;
                    end
                    lrf_pkg::PH_COL_START_H: res.bus_byte = col_start_ext[15:8];
                    lrf_pkg::PH_COL_START_L: res.bus_byte = col_start_ext[7:0];
                    lrf_pkg::PH_COL_END_H:   res.bus_byte = col_end_ext[15:8];
                    lrf_pkg::PH_COL_END_L:   res.bus_byte = col_end_ext[7:0];
                    lrf_pkg::PH_ROW_CMD:
                    begin
                        res.is_data  = 1'b0;
                        res.bus_byte = lrf_pkg::CMD_ROW_SET;
                    end
                    lrf_pkg::PH_ROW_START_H: res.bus_byte = row_start_ext[15:8];
                    lrf_pkg::PH_ROW_START_L: res.bus_byte = row_start_ext[7:0];
                    lrf_pkg::PH_ROW_END_H:   res.bus_byte = row_end_ext[15:8];
                    lrf_pkg::PH_ROW_END_L:   res.bus_byte = row_end_ext[7:0];
                    lrf_pkg::PH_MEM_CMD:
                    begin
                        res.is_data   = 1'b0;
                        res.bus_byte  = lrf_pkg::CMD_MEM_WRITE;
                        low_half_next = 1'b0;
                        // empty rectangle ends on the write command
                        res.last = (cols_left_reg == '0) || (rows_left_reg == '0);
                    end
                    lrf_pkg::PH_PIXELS:
                    begin
                        phase_next = phase_reg;
                        if (!low_half_reg)
                        begin
                            res.bus_byte  = color_reg[15:8];
                            low_half_next = 1'b1;
                        end
                        else
                        begin
                            res.bus_byte  = color_reg[7:0];
                            low_half_next = 1'b0;
                            res.last = (cols_left_reg == CB'(1)) &&
                                       (rows_left_reg == CB'(1));
                            if (cols_dec == '0)
                            begin
                                rows_left_next = rows_left_reg - CB'(1);
                                cols_left_next = reload_full[CB-1:0];
                            end
                            else
                            begin
                                cols_left_next = cols_dec;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                        busy_next  = 1'b0;
                        res_valid  = 1'b0;
                    end
                endcase
                if (res.last)
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_w_reg   <= CB'(lrf_pkg::PANEL_WIDTH_RST);
            panel_h_reg   <= CB'(lrf_pkg::PANEL_HEIGHT_RST);
            busy_reg      <= 1'b0;
            phase_reg     <= lrf_pkg::PH_COL_CMD;
            col_start_reg <= '0;
            col_end_reg   <= '0;
            row_start_reg <= '0;
            row_end_reg   <= '0;
            color_reg     <= '0;
            cols_left_reg <= '0;
            rows_left_reg <= '0;
            low_half_reg  <= 1'b0;
        end
        else
        begin
            panel_w_reg   <= panel_w_next;
            panel_h_reg   <= panel_h_next;
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            col_start_reg <= col_start_next;
            col_end_reg   <= col_end_next;
            row_start_reg <= row_start_next;
            row_end_reg   <= row_end_next;
            color_reg     <= color_next;
            cols_left_reg <= cols_left_next;
            rows_left_reg <= rows_left_next;
            low_half_reg  <= low_half_next;
        end
    end

endmodule

[design/lrf_out_reg.sv]
// ----------------------------------------------------------------------------
// lrf_out_reg: output register
// Holds one bus word until the downstream side takes it.
// ----------------------------------------------------------------------------
module lrf_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             res_valid,
    input  lrf_pkg::result_t res,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output lrf_pkg::result_t word
);

    logic             valid_reg;
    lrf_pkg::result_t word_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= res_valid;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            word_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign word     = word_reg;

endmodule

[design/lrf_checker.sv]
// ----------------------------------------------------------------------------
// lrf_checker: port checks for the rectangle-fill sequencer
// Watches the output stream for framing and command rules.
// ----------------------------------------------------------------------------
module lrf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    logic frame_open_reg, frame_open_next;
    logic out_fire;

    assign out_fire = m_tvalid && m_tready;

    // open after a word without last, closed after a last word
    always_comb
    begin
        frame_open_next = frame_open_reg;
        if (out_fire)
        begin
            frame_open_next = !m_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
        end
    end

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("output word changed under stall");

    // command bytes are only the three window/write commands
    a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == lrf_pkg::CMD_COL_SET ||
                                 m_tdata == lrf_pkg::CMD_ROW_SET ||
                                 m_tdata == lrf_pkg::CMD_MEM_WRITE)
        else $error("unknown command byte");

    // a sequence ends only on pixel data or the memory-write command
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser || m_tdata == lrf_pkg::CMD_MEM_WRITE)
        else $error("last on a bad byte");

    // after a finished sequence the next word is the column-set command
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !frame_open_reg |-> !m_tuser && m_tdata == lrf_pkg::CMD_COL_SET)
        else $error("sequence does not open with column-set");

endmodule

bind lcd_rect_fill_sequencer lrf_checker u_lrf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for lcd_rect_fill_sequencer
// Drives rectangle fills and tick words with random idling on both stream
// sides, predicts every display bus word and checks it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int CB           = lrf_pkg::COORD_BITS_DEF;
    localparam int TDATA_W      = ((4*CB+16+7)/8)*8;
    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 6;
    // two-stage pipe plus margin: idle cycles before a register write or the end
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_CYCLES = 400000;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [lrf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [CB-1:0]                   cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    // left, top, width, height, fill_color from bit 0 up
    logic [TDATA_W-1:0]              s_tdata;
    // kind
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    // bus_byte
    logic [7:0]                      m_tdata;
    // is_data
    logic                            m_tuser;
    logic                            m_tlast;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    int               cycle_count = 0;
    int               err_count   = 0;
    bit               no_idle     = 1'b0;    // when set, neither side inserts gaps
    int               rx_hold     = 0;       // one-shot long stall request for the receiver
    int               busy_words  = 0;       // words that advanced a fill
    lrf_pkg::result_t bus_words_q[$];        // predicted bus words, oldest first

    // predicted copy of the panel size registers
    logic [CB-1:0] pan_w = CB'(lrf_pkg::PANEL_WIDTH_RST);
    logic [CB-1:0] pan_h = CB'(lrf_pkg::PANEL_HEIGHT_RST);

    // predicted copy of the fill sequencer state
    bit            f_busy      = 1'b0;
    logic [3:0]    f_phase     = lrf_pkg::PH_COL_CMD;
    logic [CB-1:0] f_col_start = '0;
    logic [CB-1:0] f_row_start = '0;
    logic [CB:0]   f_col_end   = '0;
    logic [CB:0]   f_row_end   = '0;
    logic [15:0]   f_color     = '0;
    logic [CB-1:0] f_cols_left = '0;
    logic [CB-1:0] f_rows_left = '0;
    bit            f_low_next  = 1'b0;

    lcd_rect_fill_sequencer #(
        .COORD_BITS (CB)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #(CLK_PERIOD/2) clk = ~clk;

    // Watchdog: a hung handshake or a missing word ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // High byte of an 11-bit end coordinate, sign-extended: an empty
    // window at origin ends at -1 and goes out as FF FF.
    function automatic logic [7:0] end_high_byte(input logic [CB:0] e);
        return {{5{e[CB]}}, e[CB:8]};
    endfunction

    // Produce the bus word for the current phase and advance the sequence.
    function automatic void emit_fill_byte();
        lrf_pkg::result_t w;
        logic [CB:0]      span;
        w.is_data  = 1'b1;
        w.bus_byte = 8'h00;
        w.last     = 1'b0;
        case (f_phase)
            lrf_pkg::PH_COL_CMD:
            begin
                w.is_data  = 1'b0;
                w.bus_byte = lrf_pkg::CMD_COL_SET;
            end
            lrf_pkg::PH_COL_START_H: w.bus_byte = 8'(f_col_start >> 8);
            lrf_pkg::PH_COL_START_L: w.bus_byte = f_col_start[7:0];
            lrf_pkg::PH_COL_END_H:   w.bus_byte = end_high_byte(f_col_end);
            lrf_pkg::PH_COL_END_L:   w.bus_byte = f_col_end[7:0];
            lrf_pkg::PH_ROW_CMD:
            begin
                w.is_data  = 1'b0;
                w.bus_byte = lrf_pkg::CMD_ROW_SET;
            end
            lrf_pkg::PH_ROW_START_H: w.bus_byte = 8'(f_row_start >> 8);
            lrf_pkg::PH_ROW_START_L: w.bus_byte = f_row_start[7:0];
            lrf_pkg::PH_ROW_END_H:   w.bus_byte = end_high_byte(f_row_end);
            lrf_pkg::PH_ROW_END_L:   w.bus_byte = f_row_end[7:0];
            lrf_pkg::PH_MEM_CMD:
            begin
                // an empty window ends on the memory-write command
                w.is_data  = 1'b0;
                w.bus_byte = lrf_pkg::CMD_MEM_WRITE;
                f_low_next = 1'b0;
                w.last     = (f_cols_left == 0) || (f_rows_left == 0);
            end
            default:
            begin
                // pixel phase: color high byte, then low byte, per pixel
                if (!f_low_next)
                begin
                    w.bus_byte = f_color[15:8];
                    f_low_next = 1'b1;
                end
                else
                begin
                    w.bus_byte  = f_color[7:0];
                    f_low_next  = 1'b0;
                    w.last      = (f_cols_left == 1) && (f_rows_left == 1);
                    f_cols_left = f_cols_left - 1'b1;
                    if (f_cols_left == 0)
                    begin
                        // row done: reload the column count from the window
                        f_rows_left = f_rows_left - 1'b1;
                        span        = f_col_end - {1'b0, f_col_start} + 1'b1;
                        f_cols_left = span[CB-1:0];
                    end
                end
            end
        endcase
        if (f_phase != lrf_pkg::PH_PIXELS)
            f_phase = f_phase + 1'b1;
        if (w.last)
            f_busy = 1'b0;
        bus_words_q.push_back(w);
    endfunction

    // Update the prediction for one accepted input word.
    function automatic void take_word(input logic kind, input logic [TDATA_W-1:0] d);
        logic [CB-1:0] x, y, w, h;
        if (kind == lrf_pkg::KIND_START)
        begin
            x = d[CB-1:0];
            y = d[2*CB-1:CB];
            w = d[3*CB-1:2*CB];
            h = d[4*CB-1:3*CB];
            // any start abandons the fill in progress, even a dropped one
            f_busy = 1'b0;
            if (x >= pan_w || y >= pan_h)
                return;
            if ({1'b0, x} + {1'b0, w} > {1'b0, pan_w})
                w = pan_w - x;
            if ({1'b0, y} + {1'b0, h} > {1'b0, pan_h})
                h = pan_h - y;
            f_col_start = x;
            f_row_start = y;
            f_col_end   = {1'b0, x} + {1'b0, w} - 1'b1;
            f_row_end   = {1'b0, y} + {1'b0, h} - 1'b1;
            f_cols_left = w;
            f_rows_left = h;
            f_color     = d[4*CB+15:4*CB];
            f_low_next  = 1'b0;
            f_phase     = lrf_pkg::PH_COL_CMD;
            f_busy      = 1'b1;
            busy_words++;
            emit_fill_byte();
        end
        else if (f_busy)
        begin
            busy_words++;
            emit_fill_byte();
        end
    endfunction

    // Number of bus words a start would produce under the current panel size.
    function automatic int fill_length(input int x, input int y, input int w, input int h);
        if (x >= pan_w || y >= pan_h)
            return 0;
        if (x + w > pan_w)
            w = pan_w - x;
        if (y + h > pan_h)
            h = pan_h - y;
        return 11 + ((w > 0 && h > 0) ? 2 * w * h : 0);
    endfunction

    function automatic logic [TDATA_W-1:0] rand_payload();
        return TDATA_W'({$urandom(), $urandom()});
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // Compare each accepted bus word with the oldest prediction.
    always @(posedge clk)
    begin : check_bus_words
        lrf_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (bus_words_q.size() == 0)
                report_error($sformatf("unexpected word byte %02h is_data %0b last %0b",
                                       m_tdata, m_tuser, m_tlast));
            else
            begin
                want = bus_words_q.pop_front();
                if (m_tuser !== want.is_data)
                    report_error($sformatf("is_data got %0b want %0b", m_tuser, want.is_data));
                if (m_tdata !== want.bus_byte)
                    report_error($sformatf("bus_byte got %02h want %02h",
                                           m_tdata, want.bus_byte));
                if (m_tlast !== want.last)
                    report_error($sformatf("last got %0b want %0b", m_tlast, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls per word, plus one long hold on request
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                // long hold: let the block back up into its input
                m_tready = 1'b0;
                repeat (rx_hold) @(negedge clk);
                rx_hold = 0;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 4);
                if (stall > 0)
                begin
                    m_tready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            m_tready = 1'b1;
            // hold ready until a word goes through
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Sender and register access (entered and left at a falling edge)
    // ------------------------------------------------------------------
    task automatic send_word(input logic kind, input logic [TDATA_W-1:0] payload);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = kind;
        s_tdata  = payload;
        s_tvalid = 1'b1;
        // hold the word until the block takes it
        do @(posedge clk); while (!s_tready);
        take_word(kind, payload);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // One start word followed by a number of ticks with random filler data.
    task automatic send_fill(input int x, input int y, input int w, input int h,
                             input logic [15:0] color, input int ticks);
        send_word(lrf_pkg::KIND_START, {color, CB'(h), CB'(w), CB'(y), CB'(x)});
        repeat (ticks) send_word(lrf_pkg::KIND_TICK, rand_payload());
    endtask

    // Wait until every predicted word has come out and the pipe is empty.
    task automatic wait_drained();
        while (bus_words_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [lrf_pkg::CFG_INDEX_W-1:0] index,
                             input logic [CB-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (index == lrf_pkg::REG_PANEL_WIDTH)
            pan_w = value;
        else
            pan_h = value;
    endtask

    // Resize the panel only once the block has gone quiet.
    task automatic set_panel(input int w, input int h);
        wait_drained();
        write_reg(lrf_pkg::REG_PANEL_WIDTH, CB'(w));
        write_reg(lrf_pkg::REG_PANEL_HEIGHT, CB'(h));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Tick with no fill running, then starts just past the right and
    // bottom edges of the reset-size panel: none of them may emit a word.
    task automatic test_idle_and_drop();
        send_word(lrf_pkg::KIND_TICK, rand_payload());
        send_fill(lrf_pkg::PANEL_WIDTH_RST, 0, 4, 4, 16'h1234, 1);
        send_fill(0, lrf_pkg::PANEL_HEIGHT_RST, 4, 4, 16'h4321, 1);
    endtask

    // Zero-size window at origin: end coordinates go out as FF FF and the
    // memory-write command closes the sequence; the extra tick is ignored.
    task automatic test_empty_window();
        send_fill(0, 0, 0, 0, 16'h0000, 11);
    endtask

    // Oversized fill at the far corner clips to a single pixel.
    task automatic test_corner_clip();
        int cx, cy;
        cx = lrf_pkg::PANEL_WIDTH_RST - 1;
        cy = lrf_pkg::PANEL_HEIGHT_RST - 1;
        send_fill(cx, cy, 1023, 1023, 16'hFFFF, fill_length(cx, cy, 1023, 1023) - 1);
    endtask

    // Start while busy restarts the sequence; a dropped start abandons it.
    task automatic test_abandon();
        send_fill(5, 6, 2, 2, 16'h5A3C, 3);
        send_fill(0, 0, 1, 1, 16'h8001, 4);
        send_fill(600, 0, 1, 1, 16'h7FFE, 1);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // words back to back, so the block has to stall its input.
    task automatic test_backpressure();
        wait_drained();
        rx_hold = 400;
        no_idle = 1'b1;
        send_fill(10, 20, 3, 3, 16'hC3A5, fill_length(10, 20, 3, 3) - 1);
        send_fill(200, 300, 2, 1, 16'h0F0F, fill_length(200, 300, 2, 1) - 1);
        no_idle = 1'b0;
        wait_drained();
    endtask

    // Sender pauses mid-fill until the output is empty, then resumes.
    task automatic test_sender_pause();
        int len;
        len = fill_length(3, 4, 2, 2);
        send_fill(3, 4, 2, 2, 16'hB00B, 6);
        wait_drained();
        repeat (len - 7) send_word(lrf_pkg::KIND_TICK, rand_payload());
    endtask

    // Random fills: mostly complete sequences with random content, some cut
    // short by the next start, some with spare ticks, plus noise words and
    // occasional pauses until the output drains.
    task automatic run_fills(input int goal);
        int          stop_at, r, x, y, w, h, len, ticks;
        logic [15:0] color;
        stop_at = busy_words + goal;
        while (busy_words < stop_at)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            r       = $urandom_range(0, 99);
            if (r < 8)
                send_word(logic'($urandom_range(0, 1)), rand_payload());
            else if (r < 11)
                wait_drained();
            else
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        // anywhere in the coordinate range, often off-panel
                        x = $urandom_range(0, 1023);
                        y = $urandom_range(0, 1023);
                        w = $urandom_range(0, 3);
                        h = $urandom_range(0, 3);
                    end
                    1:
                    begin
                        // near the right edge with any width: clipped
                        x = (pan_w > 3) ? pan_w - $urandom_range(1, 3)
                                        : $urandom_range(0, pan_w - 1);
                        w = $urandom_range(0, 1023);
                        y = $urandom_range(0, pan_h - 1);
                        h = $urandom_range(0, 3);
                    end
                    2:
                    begin
                        // near the bottom edge with any height
                        y = (pan_h > 3) ? pan_h - $urandom_range(1, 3)
                                        : $urandom_range(0, pan_h - 1);
                        h = $urandom_range(0, 1023);
                        x = $urandom_range(0, pan_w - 1);
                        w = $urandom_range(0, 3);
                    end
                    default:
                    begin
                        x = $urandom_range(0, pan_w - 1);
                        y = $urandom_range(0, pan_h - 1);
                        w = $urandom_range(0, 3);
                        h = $urandom_range(0, 3);
                    end
                endcase
                color = 16'($urandom());
                len   = fill_length(x, y, w, h);
                r     = $urandom_range(0, 99);
                if (len == 0)
                    ticks = $urandom_range(0, 2);
                else if (r < 70)
                    ticks = len - 1;
                else if (r < 85)
                    ticks = $urandom_range(0, len - 1);
                else
                    ticks = len - 1 + $urandom_range(1, 2);
                send_fill(x, y, w, h, color, ticks);
            end
        end
        no_idle = 1'b0;
    endtask

    // Panel extremes, odd shapes and random sizes, then back to reset size.
    task automatic test_panel_sizes();
        set_panel(1023, 1023);
        run_fills(250);
        set_panel(1, 1);
        run_fills(60);
        set_panel(1, 1023);
        run_fills(60);
        set_panel(1023, 1);
        run_fills(60);
        repeat (2)
        begin
            set_panel($urandom_range(1, 1023), $urandom_range(1, 1023));
            run_fills(80);
        end
        set_panel(lrf_pkg::PANEL_WIDTH_RST, lrf_pkg::PANEL_HEIGHT_RST);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = lrf_pkg::REG_PANEL_WIDTH;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tuser   = lrf_pkg::KIND_START;
        s_tdata   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed checks run on the reset panel size
        test_idle_and_drop();
        test_empty_window();
        test_corner_clip();
        test_abandon();
        test_backpressure();
        test_sender_pause();
        test_panel_sizes();
        run_fills(600);

        // drain: anything left over shows up as a timeout
        wait_drained();
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

[filelist.f]
design/lrf_pkg.sv
design/lrf_in_reg.sv
design/lrf_seq.sv
design/lrf_out_reg.sv
design/lcd_rect_fill_sequencer.sv
design/lrf_checker.sv
dv/tb.sv
